// File: rtl/obd2_pkg.sv
// ---------------------------------------------------------------------------
// obd2_pkg
// Shared types, codes and helpers of the OBD-II poll scheduler and matcher.
// ---------------------------------------------------------------------------
package obd2_pkg;

  localparam int unsigned SlotCountDefault = 16;
  localparam int unsigned ResultCap        = 16;
  localparam int unsigned StaggerMs        = 25;
  localparam int unsigned MinFrameLen      = 3;
  localparam int unsigned MinPayloadLen    = 2;
  localparam int unsigned MaxPayloadLen    = 6;
  localparam logic [7:0]  ModeResponseBit  = 8'h40;
  localparam logic [31:0] U32Top           = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam logic [1:0] CfgActiveSlots  = 2'd0;
  localparam logic [1:0] CfgRequestId    = 2'd1;
  localparam logic [1:0] CfgResponseId   = 2'd2;

  localparam logic [10:0] RequestIdReset  = 11'd2015;
  localparam logic [10:0] ResponseIdReset = 11'd2024;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_FRAME = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic KindPoll    = 1'b0;
  localparam logic KindVerdict = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // latch a new item
    logic load;        // write one slot
    logic init_scan;   // clear scan index, count and minimum
    logic reject;      // emit a no-match verdict without scanning
    logic eval;        // evaluate the slot just read
    logic step;        // advance the scan index
    logic finish;      // close a tick scan
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_e  op;
    logic gate_ok;
    logic hit;
    logic last_slot;
  } status_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == U32Top) ? v : v + 32'd1;
  endfunction

endpackage

// File: rtl/obd2_ctrl.sv
// ---------------------------------------------------------------------------
// obd2_ctrl
// Sequencer: decodes an item, walks the slots one read/evaluate pair at a
// time and closes the scan.
// ---------------------------------------------------------------------------
module obd2_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  obd2_pkg::status_t status_i,
  output obd2_pkg::cmd_t   cmd_o,
  output logic             busy_o
);
  import obd2_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_READ   = 5'b00100,
    S_EVAL   = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        unique case (status_i.op)
          OP_LOAD: cmd_o.load = 1'b1;
          OP_TICK: begin
            if (status_i.gate_ok) begin
              cmd_o.init_scan = 1'b1;
              state_d         = S_READ;
            end
          end
          OP_FRAME: begin
            if (status_i.gate_ok) begin
              cmd_o.init_scan = 1'b1;
              state_d         = S_READ;
            end else begin
              cmd_o.reject = 1'b1;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        priority if (status_i.op == OP_FRAME && status_i.hit) begin
          state_d = S_IDLE;
        end else if (status_i.last_slot) begin
          state_d = (status_i.op == OP_TICK) ? S_DONE : S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_READ;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: rtl/obd2_datapath.sv
// ---------------------------------------------------------------------------
// obd2_datapath
// Slot tables, item register, counters, scan registers and result register.
// ---------------------------------------------------------------------------
module obd2_datapath #(
  parameter int unsigned SLOT_COUNT = obd2_pkg::SlotCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  obd2_pkg::cmd_t    cmd_i,
  output obd2_pkg::status_t status_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [10:0]       cfg_wdata_i,
  input  logic [1:0]        opcode_i,
  input  logic [31:0]       now_ms_i,
  input  logic [10:0]       frame_id_i,
  input  logic [3:0]        frame_len_i,
  input  logic [7:0]        len_byte_i,
  input  logic [7:0]        mode_echo_i,
  input  logic [7:0]        pid_echo_i,
  input  logic [3:0]        slot_index_i,
  input  logic [7:0]        slot_mode_i,
  input  logic [7:0]        slot_pid_i,
  input  logic [31:0]       slot_interval_i,
  input  logic              tx_ok_i,
  output logic              result_valid_o,
  output logic              kind_o,
  output logic [3:0]        slot_out_o,
  output logic [7:0]        req_mode_o,
  output logic [7:0]        req_pid_o,
  output logic              matched_o,
  output logic              last_o,
  output logic [31:0]       polls_sent_o,
  output logic [31:0]       responses_matched_o,
  output logic [31:0]       responses_missed_o
);
  import obd2_pkg::*;

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);

  // Slot tables
  logic [7:0]  mode_mem  [SLOT_COUNT];
  logic [7:0]  pid_mem   [SLOT_COUNT];
  logic [31:0] ivl_mem   [SLOT_COUNT];
  logic [31:0] next_mem  [SLOT_COUNT];
  logic [31:0] resp_mem  [SLOT_COUNT];

  logic [7:0]  rd_mode_q, rd_pid_q;
  logic [31:0] rd_ivl_q, rd_next_q, rd_resp_q;

  // Configuration
  logic [4:0]  active_q;
  logic [10:0] resp_id_q;

  // Item register
  logic [1:0]  op_q;
  logic [31:0] now_q;
  logic [10:0] fid_q;
  logic [3:0]  flen_q;
  logic [7:0]  plen_q, mecho_q, pecho_q;
  logic [3:0]  sidx_q;
  logic [7:0]  smode_q, spid_q;
  logic [31:0] sivl_q;
  logic        tx_q;

  // Counters and scan state
  logic [31:0] earliest_q, sent_q, matched_q, missed_q, min_q;
  logic [IdxW-1:0] idx_q;
  logic [4:0]  cnt_q;

  // Held poll result, emitted once the next one or the scan end is known
  logic        pend_q;
  logic [3:0]  pend_slot_q;
  logic [7:0]  pend_mode_q, pend_pid_q;
  logic [31:0] pend_sent_q, pend_missed_q;

  logic [CntW-1:0] n_slots;
  logic            load_ok, frame_ok, tick_ok;
  logic            due, take, miss, hit, last_slot;
  logic [31:0]     sent_nx, missed_nx, next_nx, min_nx, load_next;
  logic [IdxW-1:0] load_addr;

  // Clamp active slot count to the table size
  assign n_slots = (32'(active_q) > SLOT_COUNT) ? CntW'(SLOT_COUNT) : CntW'(active_q);

  assign tick_ok  = (n_slots != '0) && (now_q >= earliest_q);
  assign frame_ok = (n_slots != '0) && (fid_q == resp_id_q)
                    && (32'(flen_q) >= MinFrameLen)
                    && (32'(plen_q) >= MinPayloadLen) && (32'(plen_q) <= MaxPayloadLen);
  assign load_ok  = (32'(sidx_q) < SLOT_COUNT) && (sivl_q != '0);
  assign load_addr = IdxW'(sidx_q);
  assign load_next = now_q + 32'({1'b0, sidx_q} + 5'd1) * 32'(StaggerMs);

  // Evaluate the slot just read
  assign last_slot = ((CntW'(idx_q) + CntW'(1)) == n_slots);
  assign due       = (now_q >= rd_next_q);
  assign take      = due && (32'(cnt_q) < ResultCap);
  assign miss      = (rd_resp_q == '0) || (rd_resp_q < (rd_next_q - rd_ivl_q));
  assign missed_nx = (take && miss && (sent_q != '0)) ? sat_inc(missed_q) : missed_q;
  assign sent_nx   = (take && tx_q) ? sat_inc(sent_q) : sent_q;
  assign next_nx   = take ? (now_q + rd_ivl_q) : rd_next_q;
  assign min_nx    = (next_nx < min_q) ? next_nx : min_q;
  assign hit       = (mecho_q == (rd_mode_q | ModeResponseBit)) && (pecho_q == rd_pid_q);

  assign status_o.op        = op_e'(op_q);
  assign status_o.gate_ok   = (op_q == OP_TICK) ? tick_ok : frame_ok;
  assign status_o.hit       = hit;
  assign status_o.last_slot = last_slot;

  // Table writes and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      mode_mem[load_addr] <= smode_q;
      pid_mem[load_addr]  <= spid_q;
      ivl_mem[load_addr]  <= sivl_q;
      next_mem[load_addr] <= load_next;
      resp_mem[load_addr] <= '0;
    end
    if (cmd_i.eval && op_q == OP_TICK && take) begin
      next_mem[idx_q] <= next_nx;
    end
    if (cmd_i.eval && op_q == OP_FRAME && hit) begin
      resp_mem[idx_q] <= now_q;
    end
    rd_mode_q <= mode_mem[idx_q];
    rd_pid_q  <= pid_mem[idx_q];
    rd_ivl_q  <= ivl_mem[idx_q];
    rd_next_q <= next_mem[idx_q];
    rd_resp_q <= resp_mem[idx_q];
  end

  // Capture item fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      now_q   <= now_ms_i;
      fid_q   <= frame_id_i;
      flen_q  <= frame_len_i;
      plen_q  <= len_byte_i;
      mecho_q <= mode_echo_i;
      pecho_q <= pid_echo_i;
      sidx_q  <= slot_index_i;
      smode_q <= slot_mode_i;
      spid_q  <= slot_pid_i;
      sivl_q  <= slot_interval_i;
      tx_q    <= tx_ok_i;
    end
  end

  // Configuration, counters, scan state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q       <= '0;
      resp_id_q      <= ResponseIdReset;
      earliest_q     <= '0;
      sent_q         <= '0;
      matched_q      <= '0;
      missed_q       <= '0;
      min_q          <= U32Top;
      idx_q          <= '0;
      cnt_q          <= '0;
      pend_q         <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgActiveSlots) active_q  <= cfg_wdata_i[4:0];
        if (cfg_idx_i == CfgResponseId)  resp_id_q <= cfg_wdata_i;
      end
      if (cmd_i.load && load_ok) earliest_q <= '0;
      if (cmd_i.init_scan) begin
        idx_q  <= '0;
        cnt_q  <= '0;
        min_q  <= U32Top;
        pend_q <= 1'b0;
      end
      if (cmd_i.step) idx_q <= idx_q + IdxW'(1);
      if (cmd_i.reject) result_valid_o <= 1'b1;
      if (cmd_i.eval) begin
        if (op_q == OP_TICK) begin
          sent_q   <= sent_nx;
          missed_q <= missed_nx;
          min_q    <= min_nx;
          if (take) begin
            cnt_q  <= cnt_q + 5'd1;
            pend_q <= 1'b1;
            if (pend_q) result_valid_o <= 1'b1;
          end
        end else if (hit) begin
          matched_q      <= sat_inc(matched_q);
          result_valid_o <= 1'b1;
        end else if (last_slot) begin
          result_valid_o <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        earliest_q <= min_q;
        pend_q     <= 1'b0;
        if (pend_q) result_valid_o <= 1'b1;
      end
    end
  end

  // Result payload and held poll result
  always_ff @(posedge clk_i) begin
    if (cmd_i.reject) begin
      kind_o              <= KindVerdict;
      slot_out_o          <= '0;
      req_mode_o          <= '0;
      req_pid_o           <= '0;
      matched_o           <= 1'b0;
      last_o              <= 1'b1;
      polls_sent_o        <= sent_q;
      responses_matched_o <= matched_q;
      responses_missed_o  <= missed_q;
    end
    if (cmd_i.eval && op_q == OP_TICK && take) begin
      pend_slot_q   <= 4'(idx_q);
      pend_mode_q   <= rd_mode_q;
      pend_pid_q    <= rd_pid_q;
      pend_sent_q   <= sent_nx;
      pend_missed_q <= missed_nx;
    end
    if ((cmd_i.eval && op_q == OP_TICK && take) || cmd_i.finish) begin
      kind_o              <= KindPoll;
      slot_out_o          <= pend_slot_q;
      req_mode_o          <= pend_mode_q;
      req_pid_o           <= pend_pid_q;
      matched_o           <= 1'b0;
      last_o              <= cmd_i.finish;
      polls_sent_o        <= pend_sent_q;
      responses_matched_o <= matched_q;
      responses_missed_o  <= pend_missed_q;
    end
    if (cmd_i.eval && op_q == OP_FRAME) begin
      kind_o              <= KindVerdict;
      slot_out_o          <= hit ? 4'(idx_q) : 4'd0;
      req_mode_o          <= '0;
      req_pid_o           <= '0;
      matched_o           <= hit;
      last_o              <= 1'b1;
      polls_sent_o        <= sent_q;
      responses_matched_o <= hit ? sat_inc(matched_q) : matched_q;
      responses_missed_o  <= missed_q;
    end
  end

endmodule

// File: rtl/obd2_poll_scheduler_matcher_core.sv
// ---------------------------------------------------------------------------
// obd2_poll_scheduler_matcher_core
// OBD-II PID poll scheduler and response matcher, top level.
// ---------------------------------------------------------------------------
// Usage:
//   Raise start_i with an item while busy_o is low; the item is taken at
//   that edge and busy_o stays high until its work is done.
//   Results leave on result_valid_o, one cycle each; last_o marks the final
//   result of an item. The receiver cannot stall the block.
//   A load yields nothing. A tick that is not yet due ends without a scan
//   or result. A scanning tick walks the N slots in use, each with a table
//   read step and an evaluate step on the single slot table read port, then
//   closes the scan. A rejected frame does not scan; any other frame walks
//   the slots in use, ending at the first matching slot.
//   Each poll result is held until the following due slot or the scan end
//   is found, so it may trail its slot by several slot steps; the final
//   poll result of a tick appears in the cycle after the closing cycle.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   the edge and must be issued while the block is idle.
//   Reset clears counters, earliest due time and active slot count, sets
//   the response ID to its reset value; slot tables are undefined until loaded.
// ---------------------------------------------------------------------------
module obd2_poll_scheduler_matcher_core #(
  parameter int unsigned SLOT_COUNT = obd2_pkg::SlotCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] now_ms_i,
  input  logic [10:0] frame_id_i,
  input  logic [3:0]  frame_len_i,
  input  logic [7:0]  len_byte_i,
  input  logic [7:0]  mode_echo_i,
  input  logic [7:0]  pid_echo_i,
  input  logic [3:0]  slot_index_i,
  input  logic [7:0]  slot_mode_i,
  input  logic [7:0]  slot_pid_i,
  input  logic [31:0] slot_interval_i,
  input  logic        tx_ok_i,
  output logic        result_valid_o,
  output logic        kind_o,
  output logic [3:0]  slot_out_o,
  output logic [7:0]  req_mode_o,
  output logic [7:0]  req_pid_o,
  output logic        matched_o,
  output logic        last_o,
  output logic [31:0] polls_sent_o,
  output logic [31:0] responses_matched_o,
  output logic [31:0] responses_missed_o
);
  import obd2_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  obd2_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Tables, counters and result register
  obd2_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .opcode_i            (opcode_i),
    .now_ms_i            (now_ms_i),
    .frame_id_i          (frame_id_i),
    .frame_len_i         (frame_len_i),
    .len_byte_i          (len_byte_i),
    .mode_echo_i         (mode_echo_i),
    .pid_echo_i          (pid_echo_i),
    .slot_index_i        (slot_index_i),
    .slot_mode_i         (slot_mode_i),
    .slot_pid_i          (slot_pid_i),
    .slot_interval_i     (slot_interval_i),
    .tx_ok_i             (tx_ok_i),
    .result_valid_o      (result_valid_o),
    .kind_o              (kind_o),
    .slot_out_o          (slot_out_o),
    .req_mode_o          (req_mode_o),
    .req_pid_o           (req_pid_o),
    .matched_o           (matched_o),
    .last_o              (last_o),
    .polls_sent_o        (polls_sent_o),
    .responses_matched_o (responses_matched_o),
    .responses_missed_o  (responses_missed_o)
  );

  // A result only follows work the block was busy with
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result without a pending item");

  // An accepted item makes the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("item accepted but block not busy");

  // Poll requests never carry a match flag
  a_poll_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o == KindPoll) |-> !matched_o)
    else $error("poll request flagged as matched");

  // A frame verdict is always the single, final result
  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o == KindVerdict) |-> last_o)
    else $error("frame verdict not marked last");

endmodule

// File: dv/testbench.sv
// ---------------------------------------------------------------------------
// OBD-II poll scheduler and matcher testbench
// Drives loads, ticks, received frames and ignored opcodes into the core and
// checks every result against a cycle-free predictor of the slot table,
// counters and earliest due time. Configuration is changed between phases
// while the core is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import obd2_pkg::*;

  localparam int unsigned NumSlots    = 16;
  localparam int unsigned DrainCycles = 2 * NumSlots + 8;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseItems  = 67;

  typedef struct {
    op_e         op;
    bit [31:0]   now;
    bit [10:0]   frame_id;
    bit [3:0]    frame_len;
    bit [7:0]    len_byte;
    bit [7:0]    mode_echo;
    bit [7:0]    pid_echo;
    bit [3:0]    slot_index;
    bit [7:0]    slot_mode;
    bit [7:0]    slot_pid;
    bit [31:0]   slot_interval;
    bit          tx_ok;
  } item_t;

  typedef struct packed {
    bit        kind;
    bit [3:0]  slot;
    bit [7:0]  req_mode;
    bit [7:0]  req_pid;
    bit        matched;
    bit        last;
    bit [31:0] sent;
    bit [31:0] hits;
    bit [31:0] misses;
  } poll_result_t;

  // Slot table and counter predictor with its queue of pending results
  class poll_scoreboard;
    bit [7:0]     mode_tab[NumSlots];
    bit [7:0]     pid_tab[NumSlots];
    bit [31:0]    ivl_tab[NumSlots];
    bit [31:0]    next_tab[NumSlots];
    bit [31:0]    resp_tab[NumSlots];
    bit [31:0]    earliest;
    bit [31:0]    sent;
    bit [31:0]    hits;
    bit [31:0]    misses;
    bit [4:0]     active;
    bit [10:0]    req_id;
    bit [10:0]    resp_id;
    poll_result_t pending_q[$];
    int           errors;
    int           results_seen;
    int           polls_seen;
    int           matches_seen;

    function new();
      active  = 0;
      req_id  = RequestIdReset;
      resp_id = ResponseIdReset;
    endfunction

    function int slots_on();
      return (active > NumSlots) ? NumSlots : active;
    endfunction

    function bit [31:0] bump(bit [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function void write_reg(bit [1:0] idx, bit [10:0] data);
      case (idx)
        CfgActiveSlots: active  = data[4:0];
        CfgRequestId:   req_id  = data;
        CfgResponseId:  resp_id = data;
        default: ;
      endcase
    endfunction

    function void push(bit kind, int slot, bit [7:0] m, bit [7:0] p, bit hit, bit fin);
      poll_result_t r;
      r = '{kind: kind, slot: slot[3:0], req_mode: m, req_pid: p, matched: hit,
            last: fin, sent: sent, hits: hits, misses: misses};
      pending_q.push_back(r);
    endfunction

    // Work out the results that one accepted item causes
    function void note_item(item_t it);
      int          n;
      int          cnt;
      bit [31:0]   lowest;
      bit [7:0]    want;
      n = slots_on();
      case (it.op)
        OP_TICK: begin
          if (n == 0 || it.now < earliest) return;
          cnt = 0;
          for (int i = 0; i < n; i++) begin
            if (it.now < next_tab[i] || cnt >= ResultCap) continue;
            if (resp_tab[i] == 0 || resp_tab[i] < next_tab[i] - ivl_tab[i]) begin
              if (sent != 0) misses = bump(misses);
            end
            if (it.tx_ok) sent = bump(sent);
            next_tab[i] = it.now + ivl_tab[i];
            push(KindPoll, i, mode_tab[i], pid_tab[i], 1'b0, 1'b0);
            cnt++;
          end
          lowest = 32'hFFFF_FFFF;
          for (int i = 0; i < n; i++) begin
            if (next_tab[i] < lowest) lowest = next_tab[i];
          end
          earliest = lowest;
          if (cnt > 0) pending_q[pending_q.size() - 1].last = 1'b1;
        end
        OP_FRAME: begin
          if (n != 0 && it.frame_id == resp_id && it.frame_len >= MinFrameLen &&
              it.len_byte >= MinPayloadLen && it.len_byte <= MaxPayloadLen) begin
            for (int i = 0; i < n; i++) begin
              want = mode_tab[i] | ModeResponseBit;
              if (it.mode_echo != want || it.pid_echo != pid_tab[i]) continue;
              resp_tab[i] = it.now;
              hits = bump(hits);
              push(KindVerdict, i, 8'h00, 8'h00, 1'b1, 1'b1);
              return;
            end
          end
          push(KindVerdict, 0, 8'h00, 8'h00, 1'b0, 1'b1);
        end
        OP_LOAD: begin
          if (it.slot_interval == 0) return;
          mode_tab[it.slot_index] = it.slot_mode;
          pid_tab[it.slot_index]  = it.slot_pid;
          ivl_tab[it.slot_index]  = it.slot_interval;
          next_tab[it.slot_index] = it.now + (32'(it.slot_index) + 32'd1) * StaggerMs;
          resp_tab[it.slot_index] = 32'd0;
          earliest = 32'd0;
        end
        default: ;
      endcase
    endfunction

    // Compare one transfer from the result port with the oldest expectation
    function void check_result(poll_result_t got);
      poll_result_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got.kind == KindPoll) polls_seen++;
      if (got.matched) matches_seen++;
      if (got != want) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result mismatch at %0t", $realtime);
          $display("  expected %p", want);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [10:0] cfg_wdata_i;
  logic [1:0]  opcode_i;
  logic [31:0] now_ms_i;
  logic [10:0] frame_id_i;
  logic [3:0]  frame_len_i;
  logic [7:0]  len_byte_i;
  logic [7:0]  mode_echo_i;
  logic [7:0]  pid_echo_i;
  logic [3:0]  slot_index_i;
  logic [7:0]  slot_mode_i;
  logic [7:0]  slot_pid_i;
  logic [31:0] slot_interval_i;
  logic        tx_ok_i;
  logic        result_valid_o;
  logic        kind_o;
  logic [3:0]  slot_out_o;
  logic [7:0]  req_mode_o;
  logic [7:0]  req_pid_o;
  logic        matched_o;
  logic        last_o;
  logic [31:0] polls_sent_o;
  logic [31:0] responses_matched_o;
  logic [31:0] responses_missed_o;

  obd2_poll_scheduler_matcher_core dut (.*);

  poll_scoreboard sb = new();
  bit [31:0]      sim_ms;
  bit             loaded[NumSlots];
  int             items_sent;
  int             cycles;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result('{kind: kind_o, slot: slot_out_o, req_mode: req_mode_o,
                        req_pid: req_pid_o, matched: matched_o, last: last_o,
                        sent: polls_sent_o, hits: responses_matched_o,
                        misses: responses_missed_o});
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic int loaded_prefix();
    int k;
    k = 0;
    while (k < NumSlots && loaded[k]) k++;
    return k;
  endfunction

  function automatic item_t blank_item(op_e op);
    item_t it;
    it = '{op: op, now: sim_ms, frame_id: sb.resp_id, frame_len: 4'd8, len_byte: 8'd2,
           mode_echo: 8'h00, pid_echo: 8'h00, slot_index: 4'd0, slot_mode: 8'h00,
           slot_pid: 8'h00, slot_interval: 32'd1, tx_ok: 1'b1};
    return it;
  endfunction

  function automatic item_t load_item(int idx, bit [7:0] m, bit [7:0] p, bit [31:0] ivl);
    item_t it;
    it = blank_item(OP_LOAD);
    it.slot_index    = idx[3:0];
    it.slot_mode     = m;
    it.slot_pid      = p;
    it.slot_interval = ivl;
    return it;
  endfunction

  function automatic item_t frame_item(int slot, bit [10:0] id, bit [3:0] flen, bit [7:0] plen);
    item_t it;
    it = blank_item(OP_FRAME);
    it.frame_id  = id;
    it.frame_len = flen;
    it.len_byte  = plen;
    it.mode_echo = sb.mode_tab[slot] | ModeResponseBit;
    it.pid_echo  = sb.pid_tab[slot];
    return it;
  endfunction

  // Random item: mostly well-formed frames and ticks, some loads and noise
  function automatic item_t random_item();
    item_t it;
    int    r;
    int    n;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) sim_ms = $urandom;
    else sim_ms += $urandom_range(0, 120);
    n = sb.slots_on();
    if (r < 12) begin
      r = $urandom_range(0, 99);
      it = load_item($urandom_range(0, NumSlots - 1), 8'($urandom), 8'($urandom),
                     (r < 75) ? $urandom_range(1, 400) :
                     (r < 85) ? 32'($urandom) : (r < 93) ? 32'hFFFF_FFFF : 32'd0);
    end else if (r < 55) begin
      it = blank_item(OP_TICK);
      it.tx_ok = ($urandom_range(0, 9) != 0);
      it.frame_id = 11'($urandom);
    end else if (r < 95) begin
      if (n > 0 && $urandom_range(0, 99) < 75) begin
        it = frame_item($urandom_range(0, n - 1), sb.resp_id, 4'($urandom_range(3, 15)),
                        8'($urandom_range(MinPayloadLen, MaxPayloadLen)));
      end else begin
        it = blank_item(OP_FRAME);
        it.frame_id  = ($urandom_range(0, 1) != 0) ? sb.resp_id : 11'($urandom);
        it.frame_len = 4'($urandom);
        it.len_byte  = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 8)) : 8'($urandom);
        it.mode_echo = 8'($urandom);
        it.pid_echo  = 8'($urandom);
      end
    end else begin
      it = blank_item(OP_NONE);
      it.slot_interval = $urandom;
      it.slot_index    = 4'($urandom);
    end
    return it;
  endfunction

  // Offer one item and hold it until the core takes it
  task automatic send_item(item_t it);
    int gap;
    start_i         <= 1'b1;
    opcode_i        <= it.op;
    now_ms_i        <= it.now;
    frame_id_i      <= it.frame_id;
    frame_len_i     <= it.frame_len;
    len_byte_i      <= it.len_byte;
    mode_echo_i     <= it.mode_echo;
    pid_echo_i      <= it.pid_echo;
    slot_index_i    <= it.slot_index;
    slot_mode_i     <= it.slot_mode;
    slot_pid_i      <= it.slot_pid;
    slot_interval_i <= it.slot_interval;
    tx_ok_i         <= it.tx_ok;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(it);
    items_sent++;
    if (it.op == OP_LOAD && it.slot_interval != 0) loaded[it.slot_index] = 1'b1;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Let the core drain, then it is safe to write registers
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [10:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic directed_items();
    sim_ms = 32'd1000;
    // polling off: verdict without match, tick and unknown opcode silent
    send_item(frame_item(0, ResponseIdReset, 4'd8, 8'd2));
    send_item(blank_item(OP_TICK));
    send_item(blank_item(OP_NONE));
    send_item(load_item(5, 8'h01, 8'h0C, 32'd0));
    send_item(load_item(0, 8'h01, 8'h0C, 32'd10));
    send_item(load_item(1, 8'h01, 8'h0D, 32'd20));
    send_item(load_item(2, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send_item(load_item(3, 8'h00, 8'h00, 32'd50));
    wait_idle();
    write_reg(CfgActiveSlots, 11'd4);
    write_reg(CfgRequestId, 11'd2047);
    write_reg(CfgResponseId, 11'd0);
    sim_ms += 200;
    send_item(blank_item(OP_TICK));
    send_item(frame_item(2, 11'd0, 4'd3, 8'd6));
    send_item(frame_item(1, 11'd0, 4'd15, 8'd2));
    send_item(frame_item(0, 11'd1, 4'd8, 8'd2));
    send_item(frame_item(0, 11'd0, 4'd2, 8'd2));
    send_item(frame_item(0, 11'd0, 4'd8, 8'd1));
    send_item(frame_item(0, 11'd0, 4'd8, 8'd7));
    sim_ms += 5;
    send_item(blank_item(OP_TICK));
    sim_ms += 60;
    begin
      item_t t;
      t = blank_item(OP_TICK);
      t.tx_ok = 1'b0;
      send_item(t);
    end
    // time wraps past the top of the counter
    sim_ms = 32'hFFFF_FFF0;
    send_item(load_item(3, 8'h09, 8'h02, 32'd30));
    sim_ms += 100;
    send_item(blank_item(OP_TICK));
    send_item(frame_item(3, 11'd0, 4'd4, 8'd3));
  endtask

  initial begin
    int pre;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CfgActiveSlots;
    cfg_wdata_i     = '0;
    opcode_i        = OP_NONE;
    now_ms_i        = '0;
    frame_id_i      = '0;
    frame_len_i     = '0;
    len_byte_i      = '0;
    mode_echo_i     = '0;
    pid_echo_i      = '0;
    slot_index_i    = '0;
    slot_mode_i     = '0;
    slot_pid_i      = '0;
    slot_interval_i = '0;
    tx_ok_i         = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_items();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      pre = loaded_prefix();
      case (ph)
        0: write_reg(CfgActiveSlots, 11'(pre));
        1: write_reg(CfgActiveSlots, 11'd0);
        2: write_reg(CfgActiveSlots, (pre >= 1) ? 11'd1 : 11'd0);
        3: write_reg(CfgActiveSlots, (pre == NumSlots) ? 11'd31 : 11'(pre));
        4: write_reg(CfgActiveSlots, 11'($urandom_range(0, pre)));
        default: write_reg(CfgActiveSlots, 11'(pre));
      endcase
      write_reg(CfgRequestId, (ph == 1) ? 11'd0 : 11'($urandom));
      case (ph % 3)
        0: write_reg(CfgResponseId, 11'd2047);
        1: write_reg(CfgResponseId, ResponseIdReset);
        default: write_reg(CfgResponseId, 11'($urandom));
      endcase
      for (int k = 0; k < PhaseItems; k++) send_item(random_item());
      // load all slots so the widest settings become legal
      if (ph == 1) begin
        for (int s = 0; s < NumSlots; s++) begin
          if (!loaded[s]) begin
            send_item(load_item(s, 8'($urandom), 8'($urandom), $urandom_range(1, 300)));
          end
        end
      end
    end

    wait_idle();
    $display("Run covered %0d items in %0d cycles: %0d results, %0d poll requests,",
             items_sent, cycles, sb.results_seen, sb.polls_seen);
    $display("%0d matched responses, %0d mismatches", sb.matches_seen, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: obd2_poll_scheduler_matcher_core.f
rtl/obd2_pkg.sv
rtl/obd2_ctrl.sv
rtl/obd2_datapath.sv
rtl/obd2_poll_scheduler_matcher_core.sv
dv/testbench.sv
